// File: sv/dual_pwm_drift_balancer_defines.svh
// Assertion helpers used by the checker in dpdb_checker.sv.
`ifndef DUAL_PWM_DRIFT_BALANCER_DEFINES_SVH
`define DUAL_PWM_DRIFT_BALANCER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPDB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPDB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dpdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpdb_pkg;

  localparam int unsigned PWM_PERIOD = 100;
  localparam int unsigned DUTY_STEP  = 3;

  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned DUTY_XW   = DUTY_W + 1;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned GAIN_FRAC = 14;
  localparam int unsigned PROD_W    = CNT_W + GAIN_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_DUTY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd2;

  localparam logic [DUTY_W-1:0]  START_DUTY_RST   = 7'd30;
  localparam logic [GAIN_W-1:0]  BALANCE_GAIN_RST = 16'd16216;
  localparam logic [CNT_W-1:0]   TARGET_COUNT_RST = 32'd0;

  typedef enum logic {
    ACTION_TICK  = 1'b0,
    ACTION_START = 1'b1
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [CNT_W-1:0]   left_count;
    logic [CNT_W-1:0]   right_count;
  } req_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  start_duty;
    logic [GAIN_W-1:0]  balance_gain;
    logic [CNT_W-1:0]   target_count;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  phase;
    logic [DUTY_W-1:0]  left_duty;
    logic [DUTY_W-1:0]  right_duty;
    logic [CNT_W-1:0]   left_origin;
    logic [CNT_W-1:0]   right_origin;
    logic               finished;
  } state_t;

  typedef struct packed {
    logic               left_pwm;
    logic               right_pwm;
    logic               done_res;
    logic [DUTY_W-1:0]  left_duty_now;
    logic [DUTY_W-1:0]  right_duty_now;
  } res_t;

endpackage

`default_nettype wire

// File: sv/dpdb_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One control step: next state and result for one request.
module dpdb_step (
  input  dpdb_pkg::req_t   req_i,
  input  dpdb_pkg::cfg_t   cfg_i,
  input  dpdb_pkg::state_t state_i,
  output dpdb_pkg::state_t state_o,
  output dpdb_pkg::res_t   res_o
);

  localparam logic [dpdb_pkg::DUTY_W-1:0] PERIOD_D =
    dpdb_pkg::DUTY_W'(dpdb_pkg::PWM_PERIOD);
  localparam logic [dpdb_pkg::DUTY_XW-1:0] PERIOD_X =
    dpdb_pkg::DUTY_XW'(dpdb_pkg::PWM_PERIOD);
  localparam logic [dpdb_pkg::DUTY_W-1:0] STEP_D =
    dpdb_pkg::DUTY_W'(dpdb_pkg::DUTY_STEP);
  localparam logic [dpdb_pkg::DUTY_XW-1:0] STEP_X =
    dpdb_pkg::DUTY_XW'(dpdb_pkg::DUTY_STEP);

  logic [dpdb_pkg::DUTY_XW-1:0] phase_inc;
  logic [dpdb_pkg::DUTY_W-1:0]  phase_nxt;
  logic [dpdb_pkg::DUTY_W-1:0]  start_clamped;
  logic [dpdb_pkg::CNT_W-1:0]   ltrav, rtrav;
  logic [dpdb_pkg::PROD_W-1:0]  rhs, lhs;
  logic                         lp, rp;
  logic                         to_right_ok, to_left_ok;

  assign phase_inc = {1'b0, state_i.phase} + dpdb_pkg::DUTY_XW'(1);
  assign phase_nxt = (phase_inc >= PERIOD_X) ? '0 : phase_inc[dpdb_pkg::DUTY_W-1:0];

  // PWM levels use the duties before this step's correction
  assign lp = (phase_nxt < state_i.left_duty);
  assign rp = (phase_nxt < state_i.right_duty);

  assign ltrav = req_i.left_count  - state_i.left_origin;
  assign rtrav = req_i.right_count - state_i.right_origin;

  // right * gain against left << 14, both exact in 48 bits
  assign rhs = {{dpdb_pkg::GAIN_W{1'b0}}, rtrav} *
               {{dpdb_pkg::CNT_W{1'b0}}, cfg_i.balance_gain};
  assign lhs = {{(dpdb_pkg::GAIN_W - dpdb_pkg::GAIN_FRAC){1'b0}}, ltrav,
                {dpdb_pkg::GAIN_FRAC{1'b0}}};

  assign to_right_ok = (({1'b0, state_i.right_duty} + STEP_X) <= PERIOD_X) &&
                       (state_i.left_duty >= STEP_D);
  assign to_left_ok  = (({1'b0, state_i.left_duty} + STEP_X) <= PERIOD_X) &&
                       (state_i.right_duty >= STEP_D);

  assign start_clamped = (cfg_i.start_duty > PERIOD_D) ? PERIOD_D : cfg_i.start_duty;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (req_i.action == dpdb_pkg::ACTION_START) begin
      state_o.left_origin  = req_i.left_count;
      state_o.right_origin = req_i.right_count;
      state_o.left_duty    = start_clamped;
      state_o.right_duty   = start_clamped;
      state_o.phase        = '0;
      state_o.finished     = 1'b0;
    end else if (!state_i.finished) begin
      state_o.phase = phase_nxt;
      if (rhs < lhs) begin
        if (to_right_ok) begin
          state_o.right_duty = state_i.right_duty + STEP_D;
          state_o.left_duty  = state_i.left_duty  - STEP_D;
        end
      end else if (lhs < rhs) begin
        if (to_left_ok) begin
          state_o.left_duty  = state_i.left_duty  + STEP_D;
          state_o.right_duty = state_i.right_duty - STEP_D;
        end
      end
      if (ltrav >= cfg_i.target_count) begin
        state_o.finished = 1'b1;
        res_o.done_res   = 1'b1;
      end else begin
        res_o.left_pwm  = lp;
        res_o.right_pwm = rp;
      end
    end else begin
      res_o.done_res = 1'b1;
    end
    res_o.left_duty_now  = state_o.left_duty;
    res_o.right_duty_now = state_o.right_duty;
  end

endmodule

`default_nettype wire

// File: sv/dual_pwm_drift_balancer.sv
// Data path: a request is taken into the request register, the step moves it
// into the result register, and the result is taken from there.
// Throughput: one request per cycle while the result is not stalled; the step
// logic between the request register and the result register is combinational.
// A stalled result holds the result register; the request register keeps
// filling, so one extra request is taken while the result waits.
// Reset (rst_ni low, async): no request/result held, run finished, duties,
// phase and origins zero, registers at start_duty 30, gain 16216, target 0.
`timescale 1ns / 1ps
`default_nettype none

module dual_pwm_drift_balancer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [dpdb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dpdb_pkg::CFG_DW-1:0]          cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic [dpdb_pkg::CNT_W-1:0]           left_count_i,
  input  logic [dpdb_pkg::CNT_W-1:0]           right_count_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 left_pwm_o,
  output logic                                 right_pwm_o,
  output logic                                 done_res_o,
  output logic [dpdb_pkg::DUTY_W-1:0]          left_duty_now_o,
  output logic [dpdb_pkg::DUTY_W-1:0]          right_duty_now_o
);

  // configuration registers
  dpdb_pkg::cfg_t   cfg_q;

  // request register
  logic             req_valid_q;
  dpdb_pkg::req_t   req_q;

  // controller state
  dpdb_pkg::state_t state_q, state_d;

  // result register
  logic             res_valid_q;
  dpdb_pkg::res_t   res_q, res_d;

  logic             step_go;   // request register moves into the result register
  logic             in_take;   // new request accepted this cycle

  // The step runs when a request is held and the result slot is free or
  // being emptied this cycle.
  assign step_go    = req_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !step_go;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_duty   <= dpdb_pkg::START_DUTY_RST;
      cfg_q.balance_gain <= dpdb_pkg::BALANCE_GAIN_RST;
      cfg_q.target_count <= dpdb_pkg::TARGET_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dpdb_pkg::REG_START_DUTY:
          cfg_q.start_duty <= cfg_wdata_i[dpdb_pkg::DUTY_W-1:0];
        dpdb_pkg::REG_BALANCE_GAIN:
          cfg_q.balance_gain <= cfg_wdata_i[dpdb_pkg::GAIN_W-1:0];
        dpdb_pkg::REG_TARGET_COUNT:
          cfg_q.target_count <= cfg_wdata_i[dpdb_pkg::CNT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // Request register: payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_take) begin
      req_valid_q <= 1'b1;
    end else if (step_go) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.action      <= dpdb_pkg::action_e'(action_i);
      req_q.left_count  <= left_count_i;
      req_q.right_count <= right_count_i;
    end
  end

  dpdb_step u_step (
    .req_i   (req_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // State commits with each step, so the next request sees it right away.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= '0;
      state_q.left_duty    <= '0;
      state_q.right_duty   <= '0;
      state_q.left_origin  <= '0;
      state_q.right_origin <= '0;
      state_q.finished     <= 1'b1;  // idle until the first start
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_go) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign left_pwm_o       = res_q.left_pwm;
  assign right_pwm_o      = res_q.right_pwm;
  assign done_res_o       = res_q.done_res;
  assign left_duty_now_o  = res_q.left_duty_now;
  assign right_duty_now_o = res_q.right_duty_now;

endmodule

`default_nettype wire

// File: sv/dpdb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dual_pwm_drift_balancer_defines.svh"

module dpdb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        left_pwm_o,
  input logic                        right_pwm_o,
  input logic                        done_res_o,
  input logic [dpdb_pkg::DUTY_W-1:0] left_duty_now_o,
  input logic [dpdb_pkg::DUTY_W-1:0] right_duty_now_o
);

  localparam logic [dpdb_pkg::DUTY_W-1:0] PERIOD_D =
    dpdb_pkg::DUTY_W'(dpdb_pkg::PWM_PERIOD);

  logic                            done_seen;
  logic                            pwm_any;
  logic                            duty_ok;
  logic                            res_wait;
  logic [2*dpdb_pkg::DUTY_W+2:0]   res_vec;

  assign done_seen = out_valid_o && done_res_o;
  assign pwm_any   = left_pwm_o || right_pwm_o;
  assign duty_ok   = (left_duty_now_o <= PERIOD_D) && (right_duty_now_o <= PERIOD_D);
  assign res_wait  = out_valid_o && out_stall_i;
  assign res_vec   = {left_pwm_o, right_pwm_o, done_res_o, left_duty_now_o,
                      right_duty_now_o};

  // a finished run never drives the motors
  `DPDB_ASSERT_NOW(a_done_pwm_low, done_seen, !pwm_any, "pwm high on a done result")

  // duties stay within the period
  `DPDB_ASSERT_NOW(a_duty_range, out_valid_o, duty_ok, "duty beyond period")

  // a stalled result stays put
  `DPDB_ASSERT_NEXT(a_hold, res_wait, out_valid_o && $stable(res_vec), "stalled result moved")

endmodule

bind dual_pwm_drift_balancer dpdb_checker u_dpdb_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .left_pwm_o       (left_pwm_o),
  .right_pwm_o      (right_pwm_o),
  .done_res_o       (done_res_o),
  .left_duty_now_o  (left_duty_now_o),
  .right_duty_now_o (right_duty_now_o)
);

`default_nettype wire
